// ----- design/rlbd_pkg.sv -----
package rlbd_pkg;

    localparam int MAX_LEVELS  = 6;
    localparam int SAMPLE_BITS = 10;
    localparam int LEVEL_REGS  = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int COUNT_W    = 3;
    localparam int TOL_W      = 10;
    localparam int ADC_W      = 10;
    localparam int BUTTON_W   = 3;
    localparam int RAW_W      = 4;
    localparam int TIME_W     = 32;
    localparam int DUR_W      = 16;
    localparam int CMP_W      = (SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W;
    localparam int LVL_IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TIME_W-1:0]      t_time;
    typedef logic [LVL_IDX_W-1:0]   t_level_idx;

    localparam logic [CFG_IDX_W-1:0] REG_LEVELS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOL     = CFG_IDX_W'(1);
    localparam int                   REG_LEVEL_BASE    = 2;

    localparam logic [COUNT_W-1:0] RST_LEVELS_IN_USE = COUNT_W'(6);
    localparam logic [TOL_W-1:0]   RST_MATCH_TOL     = TOL_W'(8);
    localparam t_sample            RST_LEVEL_OPEN    = SAMPLE_BITS'(1023);

    localparam logic [RAW_W-1:0] RAW_NO_MATCH = {RAW_W{1'b1}};

endpackage

// ----- design/resistor_ladder_button_decoder.sv -----
// Resistor-ladder keypad decoder.
// Input channel (i_in_valid / o_in_ready) takes one word per ADC sample of
// the ladder pin together with the free-running millisecond time. Output
// channel (o_out_valid / i_out_ready) gives one word per input word: the
// latched button, the first matching ladder level (-1 if none), the press
// length in ms saturated at 16 bits, and a held flag.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// register i_cfg_index: 0 levels in use, 1 match tolerance, 2..7 the ladder
// levels for open and buttons one to five. Write only while idle.
// The result word passes through the input register, then the result
// register, where it is held until taken. Throughput: one word per cycle
// while the receiver takes each result; the level compare, latch update and
// duration subtract are combinational between the two registers.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more word; the block then deasserts
// o_in_ready until the result is taken.
// Reset (synchronous, active low) empties both registers, clears the latch
// and press times, and restores the register defaults.
module resistor_ladder_button_decoder
    import rlbd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [ADC_W-1:0]        i_adc_sample,
    input  logic [TIME_W-1:0]       i_now_ms,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [BUTTON_W-1:0]     o_pressed_button,
    output logic signed [RAW_W-1:0] o_raw_match,
    output logic [DUR_W-1:0]        o_press_duration_ms,
    output logic                    o_button_held
);

    logic [COUNT_W-1:0]  r_levels_in_use;
    logic [TOL_W-1:0]    r_match_tol;
    t_sample             r_level [MAX_LEVELS];

    logic                r_in_valid;
    t_sample             r_in_sample;
    t_time               r_in_now;

    logic [BUTTON_W-1:0] r_latched;
    t_time               r_start;
    t_time               r_end;
    logic                r_seen;
    logic                r_released;

    logic                r_out_valid;
    logic [BUTTON_W-1:0] r_pressed_button;
    logic [RAW_W-1:0]    r_raw_match;
    logic [DUR_W-1:0]    r_duration;

    logic                advance;
    logic                in_take;

    logic                found;
    t_level_idx          match_idx;
    logic [RAW_W-1:0]    n_raw;
    logic [BUTTON_W-1:0] n_latched;
    t_time               n_start;
    t_time               n_end;
    logic                n_seen;
    logic                n_released;
    t_time               elapsed;
    logic [DUR_W-1:0]    n_duration;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels_in_use <= RST_LEVELS_IN_USE;
            r_match_tol     <= RST_MATCH_TOL;
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_level[l] <= (l == 0) ? RST_LEVEL_OPEN : '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LEVELS_IN_USE: r_levels_in_use <= COUNT_W'(i_cfg_data);
                REG_MATCH_TOL:     r_match_tol     <= TOL_W'(i_cfg_data);
                default: begin
                    for (int l = 0; l < MAX_LEVELS; l++) begin
                        if (l < LEVEL_REGS &&
                            i_cfg_index == CFG_IDX_W'(REG_LEVEL_BASE + l)) begin
                            r_level[l] <= SAMPLE_BITS'(i_cfg_data);
                        end
                    end
                end
            endcase
        end
    end

    // first level within tolerance wins
    always_comb begin
        t_sample lv_diff;
        found     = 1'b0;
        match_idx = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            lv_diff = (r_in_sample >= r_level[l]) ? r_in_sample - r_level[l]
                                                  : r_level[l] - r_in_sample;
            if (!found && int'(r_levels_in_use) > l &&
                CMP_W'(lv_diff) <= CMP_W'(r_match_tol)) begin
                found     = 1'b1;
                match_idx = LVL_IDX_W'(l);
            end
        end
    end

    always_comb begin
        n_raw      = found ? RAW_W'(match_idx) : RAW_NO_MATCH;
        n_latched  = r_latched;
        n_start    = r_start;
        n_end      = r_end;
        n_seen     = r_seen;
        n_released = r_released;
        if (found && match_idx == '0) begin
            if (r_latched != '0) begin
                n_end      = r_in_now;
                n_released = 1'b1;
                n_latched  = '0;
            end
        end else if (found && r_latched == '0) begin
            n_start    = r_in_now;
            n_end      = '0;
            n_seen     = 1'b1;
            n_released = 1'b0;
            n_latched  = BUTTON_W'(match_idx);
        end
        elapsed = (n_released ? n_end : r_in_now) - n_start;
        if (!n_seen) begin
            n_duration = '0;
        end else if (elapsed[TIME_W-1:DUR_W] != '0) begin
            n_duration = '1;
        end else begin
            n_duration = elapsed[DUR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_latched   <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_seen      <= 1'b0;
            r_released  <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_latched   <= n_latched;
                r_start     <= n_start;
                r_end       <= n_end;
                r_seen      <= n_seen;
                r_released  <= n_released;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= SAMPLE_BITS'(i_adc_sample);
            r_in_now    <= i_now_ms;
        end
        if (advance) begin
            r_pressed_button <= n_latched;
            r_raw_match      <= n_raw;
            r_duration       <= n_duration;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_pressed_button    = r_pressed_button;
    assign o_raw_match         = r_raw_match;
    assign o_press_duration_ms = r_duration;
    assign o_button_held       = r_pressed_button != '0;

    a_latch_implies_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched != '0 |-> r_seen && !r_released)
        else $error("button latched without an open press");

    a_open_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_raw_match == '0 |-> o_pressed_button == '0)
        else $error("open sample left a button latched");

    a_press_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_raw_match > 0 |-> o_pressed_button != '0)
        else $error("button match with nothing latched");

    a_stall_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |=> r_out_valid && r_in_valid)
        else $error("word lost while the receiver stalled");

    a_released_holds_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_released && r_latched == '0 && !(found && match_idx != '0)
        |=> $stable(r_start) && $stable(r_end))
        else $error("press times changed without a new press");

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rlbd_pkg::*;

    typedef struct packed {
        logic [ADC_W-1:0]  sample;
        logic [TIME_W-1:0] now;
    } t_adc_word;

    typedef struct packed {
        logic [BUTTON_W-1:0] button;
        logic [RAW_W-1:0]    raw;
        logic [DUR_W-1:0]    dur;
        logic                held;
    } t_key_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [ADC_W-1:0]      i_adc_sample = '0;
    logic [TIME_W-1:0]     i_now_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [BUTTON_W-1:0]   o_pressed_button;
    logic signed [RAW_W-1:0] o_raw_match;
    logic [DUR_W-1:0]      o_press_duration_ms;
    logic                  o_button_held;

    resistor_ladder_button_decoder u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_adc_sample        (i_adc_sample),
        .i_now_ms            (i_now_ms),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_pressed_button    (o_pressed_button),
        .o_raw_match         (o_raw_match),
        .o_press_duration_ms (o_press_duration_ms),
        .o_button_held       (o_button_held)
    );

    always #5 i_clk = ~i_clk;

    t_adc_word   adc_words_pending[$];
    t_key_report expected_reports[$];
    int          error_count = 0;
    int          report_count = 0;

    // decoder model: configuration and latch state
    logic [COUNT_W-1:0]     cfg_levels_in_use = RST_LEVELS_IN_USE;
    logic [TOL_W-1:0]       cfg_tolerance = RST_MATCH_TOL;
    logic [SAMPLE_BITS-1:0] cfg_level [MAX_LEVELS];
    logic [BUTTON_W-1:0]    latched_key = '0;
    logic [TIME_W-1:0]      press_start_ms = '0;
    logic [TIME_W-1:0]      press_end_ms = '0;
    logic                   press_seen = 1'b0;
    logic                   press_released = 1'b0;

    logic [TIME_W-1:0]      sim_ms = '0;

    function automatic int levels_compared();
        return (cfg_levels_in_use > MAX_LEVELS) ? MAX_LEVELS : int'(cfg_levels_in_use);
    endfunction

    function automatic t_key_report decode_sample(input logic [ADC_W-1:0] sample,
                                                  input logic [TIME_W-1:0] now);
        t_key_report       rep;
        int                hit;
        int                diff;
        int                i;
        logic [TIME_W-1:0] span;
        hit = -1;
        for (i = 0; i < levels_compared(); i++) begin
            diff = int'(sample) - int'(cfg_level[i]);
            if (diff < 0)
                diff = -diff;
            if (hit < 0 && diff <= int'(cfg_tolerance))
                hit = i;
        end
        if (hit == 0) begin
            if (latched_key != '0) begin
                press_end_ms = now;
                press_released = 1'b1;
                latched_key = '0;
            end
        end else if (hit > 0 && latched_key == '0) begin
            press_start_ms = now;
            press_end_ms = '0;
            press_seen = 1'b1;
            press_released = 1'b0;
            latched_key = BUTTON_W'(hit);
        end
        rep.dur = '0;
        if (press_seen) begin
            span = press_released ? press_end_ms - press_start_ms : now - press_start_ms;
            rep.dur = (span > 32'hFFFF) ? '1 : span[DUR_W-1:0];
        end
        rep.button = latched_key;
        rep.raw = (hit < 0) ? RAW_NO_MATCH : RAW_W'(hit);
        rep.held = (latched_key != '0);
        return rep;
    endfunction

    // sender: bursts of random length, random gaps
    int gap_left = 0;
    int burst_left = 0;

    always @(posedge i_clk) begin : drive_samples
        t_adc_word next_word;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_reports.push_back(decode_sample(i_adc_sample, i_now_ms));
            if (i_in_valid && !o_in_ready) begin
                // hold the word
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (adc_words_pending.size() > 0) begin
                next_word = adc_words_pending.pop_front();
                i_in_valid <= 1'b1;
                i_adc_sample <= next_word.sample;
                i_now_ms <= next_word.now;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(50, 150);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 6);
                    end
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off now and then
    int          hold_left = 0;
    int          pattern_pos = 0;
    logic [31:0] ready_pattern = '1;

    always @(posedge i_clk) begin : check_reports
        t_key_report want;
        t_key_report got;
        logic        ready_next;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_pressed_button, o_raw_match, o_press_duration_ms, o_button_held};
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected word button=%0d raw=%0d dur=%0d held=%0b",
                         $time, got.button, $signed(got.raw), got.dur, got.held);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected button=%0d raw=%0d dur=%0d held=%0b",
                             $time, want.button, $signed(want.raw), want.dur, want.held);
                    $display("%0t:          actual   button=%0d raw=%0d dur=%0d held=%0b",
                             $time, got.button, $signed(got.raw), got.dur, got.held);
                    error_count++;
                end
            end
            report_count++;
            if (report_count % 600 == 300)
                hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            if (pattern_pos == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = '1;
                    1: ready_pattern = $urandom;
                    2: ready_pattern = $urandom | $urandom;
                    default: ready_pattern = $urandom & $urandom;
                endcase
            end
            ready_next = ready_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 32;
        end
        i_out_ready <= ready_next;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        int k;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        k = int'(idx) - REG_LEVEL_BASE;
        if (idx == REG_LEVELS_IN_USE)
            cfg_levels_in_use = data[COUNT_W-1:0];
        else if (idx == REG_MATCH_TOL)
            cfg_tolerance = data[TOL_W-1:0];
        else if (k >= 0 && k < MAX_LEVELS)
            cfg_level[k] = data[SAMPLE_BITS-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int count, input int tol, input int lv[LEVEL_REGS]);
        logic [CFG_DATA_W-1:0] upper;
        int                    k;
        upper = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
        write_reg(REG_LEVELS_IN_USE, (upper & ~CFG_DATA_W'(7)) | CFG_DATA_W'(count));
        write_reg(REG_MATCH_TOL, CFG_DATA_W'(tol));
        for (k = 0; k < LEVEL_REGS; k++)
            write_reg(CFG_IDX_W'(REG_LEVEL_BASE + k), CFG_DATA_W'(lv[k]));
    endtask

    task automatic queue_word(input logic [ADC_W-1:0] sample, input logic [TIME_W-1:0] now);
        t_adc_word w;
        w.sample = sample;
        w.now = now;
        adc_words_pending.push_back(w);
        sim_ms = now;
    endtask

    task automatic queue_after(input logic [ADC_W-1:0] sample);
        logic [TIME_W-1:0] now;
        case ($urandom_range(0, 29))
            0: now = sim_ms + $urandom_range(60000, 80000);
            1: now = $urandom;
            default: now = sim_ms + $urandom_range(0, 40);
        endcase
        queue_word(sample, now);
    endtask

    task automatic queue_near(input int key);
        int off;
        int s;
        int tol;
        if (levels_compared() == 0) begin
            queue_after(ADC_W'($urandom));
        end else begin
            tol = int'(cfg_tolerance);
            case ($urandom_range(0, 7))
                0: off = tol;
                1: off = -tol;
                2: off = tol + 1;
                3: off = -tol - 1;
                default: off = int'($urandom_range(0, 2 * tol)) - tol;
            endcase
            s = int'(cfg_level[key]) + off;
            if (s < 0)
                s = 0;
            if (s > 1023)
                s = 1023;
            queue_after(ADC_W'(s));
        end
    endtask

    task automatic queue_press_sequence();
        int n;
        int key;
        n = levels_compared();
        key = (n > 1) ? $urandom_range(1, n - 1) : 0;
        repeat ($urandom_range(1, 3))
            queue_near(0);
        repeat ($urandom_range(1, 6)) begin
            queue_near(key);
            if ($urandom_range(0, 5) == 0)
                queue_after(ADC_W'($urandom));
        end
        if (n > 2 && $urandom_range(0, 2) == 0)
            queue_near($urandom_range(1, n - 1));
        repeat ($urandom_range(1, 3))
            queue_near(0);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (adc_words_pending.size() != 0 || i_in_valid || expected_reports.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : run_phases
        logic [TIME_W-1:0] t0;
        int                lv[LEVEL_REGS];
        int                ph;
        int                count;
        int                tol;
        int                k;
        for (k = 0; k < MAX_LEVELS; k++)
            cfg_level[k] = '0;
        cfg_level[0] = RST_LEVEL_OPEN;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset levels: press, wrap of the ms time, saturation, release
        t0 = 32'hFFFF_FFF0;
        queue_word(10'd1023, t0);
        queue_word(10'd512, t0 + 32'd1);
        queue_word(10'd0, t0 + 32'd2);
        queue_word(10'd8, t0 + 32'd5);
        queue_word(10'd9, t0 + 32'd6);
        queue_word(10'd1015, 32'd20);
        queue_word(10'd1014, 32'd25);
        queue_word(10'd3, 32'd30);
        queue_word(10'd3, 32'd70030);
        queue_word(10'd1023, 32'd70031);
        queue_word(10'd1023, 32'h8000_0000);
        queue_word(10'd1016, 32'h8000_0001);
        wait_idle();

        // distinct levels: direct change, repeat, unmatched, edges of tolerance
        lv = '{1000, 100, 300, 500, 700, 900};
        apply_setting(6, 20, lv);
        @(negedge i_clk);
        queue_after(10'd1000);
        queue_after(10'd300);
        queue_after(10'd500);
        queue_after(10'd300);
        queue_after(10'd200);
        queue_after(10'd980);
        queue_after(10'd921);
        queue_after(10'd880);
        queue_after(10'd1023);
        queue_after(10'd1020);
        wait_idle();

        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                0: count = 7;
                1: count = 1;
                2: count = 0;
                3: count = 6;
                default: count = $urandom_range(2, 6);
            endcase
            case (ph)
                0: tol = 0;
                3: tol = 1023;
                5: tol = $urandom_range(100, 300);
                7: tol = 0;
                default: tol = $urandom_range(1, 40);
            endcase
            for (k = 0; k < LEVEL_REGS; k++)
                lv[k] = $urandom_range(0, 1023);
            if (ph == 4)
                lv = '{0, 1023, 1023, 0, 1, 1022};
            if (ph == 6) begin
                lv[0] = 1023;
                for (k = 1; k < LEVEL_REGS; k++)
                    lv[k] = (k - 1) * 200 + $urandom_range(0, 40);
            end
            apply_setting(count, tol, lv);
            @(negedge i_clk);
            while (adc_words_pending.size() < 190) begin
                if ($urandom_range(0, 9) < 8) begin
                    queue_press_sequence();
                end else begin
                    repeat ($urandom_range(1, 4))
                        queue_after(ADC_W'($urandom));
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("resistor_ladder_button_decoder verification clean");
        else
            $display("resistor_ladder_button_decoder verification failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("resistor_ladder_button_decoder verification failed");
        $finish;
    end

endmodule
